// ----- hdl/lwfb_pkg.sv -----
`default_nettype none

package lwfb_pkg;

  localparam logic [7:0] CmdColumnSet   = 8'h2A;
  localparam logic [7:0] CmdPageSet     = 8'h2B;
  localparam logic [7:0] CmdMemoryWrite = 8'h2C;
  localparam int unsigned ArgWidth      = 16;

  typedef enum logic {
    OpRequest = 1'b0,
    OpTick    = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    HdrColCmd,
    HdrColStartHi,
    HdrColStartLo,
    HdrColEndHi,
    HdrColEndLo,
    HdrRowCmd,
    HdrRowStartHi,
    HdrRowStartLo,
    HdrRowEndHi,
    HdrRowEndLo,
    HdrRamCmd,
    HdrColor
  } hdr_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       sel_rel;
    logic       last;
  } res_t;

  typedef struct packed {
    logic busy;
    hdr_e hdr;
    logic low_half;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/lwfb_clip.sv -----
`default_nettype none

module lwfb_clip
  import lwfb_pkg::*;
#(
  parameter int unsigned CW = 9
) (
  input  wire logic signed [ArgWidth-1:0] start_i,
  input  wire logic signed [ArgWidth-1:0] size_i,
  input  wire logic        [CW:0]         limit_i,
  output logic                            ok_o,
  output logic             [CW-1:0]       first_o,
  output logic             [CW-1:0]       final_o,
  output logic             [CW:0]         count_o
);

  logic signed [ArgWidth+1:0] s, z, lim, s2, z2, e, e_c, cnt;
  logic                       bad0, bad1;

  always_comb begin
    s   = {{2{start_i[ArgWidth-1]}}, start_i};
    z   = {{2{size_i[ArgWidth-1]}}, size_i};
    lim = $signed((ArgWidth+2)'(limit_i));
    bad0 = (z <= 0) || (s >= lim);
    if (s < 0) begin
      z2 = z + s;
      s2 = '0;
    end else begin
      z2 = z;
      s2 = s;
    end
    bad1 = (z2 <= 0);
    e = s2 + z2 - (ArgWidth+2)'(1);
    if (e >= lim) begin
      e_c = lim - (ArgWidth+2)'(1);
    end else begin
      e_c = e;
    end
    cnt     = e_c - s2 + (ArgWidth+2)'(1);
    ok_o    = !bad0 && !bad1;
    first_o = s2[CW-1:0];
    final_o = e_c[CW-1:0];
    count_o = cnt[CW:0];
  end

endmodule

`default_nettype wire

// ----- hdl/lwfb_seq.sv -----
`default_nettype none

module lwfb_seq
  import lwfb_pkg::*;
#(
  parameter int unsigned CW = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 tick_i,
  input  wire logic                 col_ok_i,
  input  wire logic        [CW-1:0] col_first_i,
  input  wire logic        [CW-1:0] col_final_i,
  input  wire logic        [CW:0]   col_count_i,
  input  wire logic                 row_ok_i,
  input  wire logic        [CW-1:0] row_first_i,
  input  wire logic        [CW-1:0] row_final_i,
  input  wire logic        [CW:0]   row_count_i,
  input  wire logic        [15:0]   color_i,
  output status_t                   status_o,
  output res_t                      res_o
);

  logic          busy_q, busy_d;
  hdr_e          hdr_q, hdr_d;
  logic          low_q, low_d;
  logic [CW-1:0] cs_q, ce_q, rs_q, re_q;
  logic [CW:0]   width_q, col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [15:0]   color_q;
  logic [15:0]   cs16, ce16, rs16, re16;
  logic          load, fin;

  assign cs16 = 16'(cs_q);
  assign ce16 = 16'(ce_q);
  assign rs16 = 16'(rs_q);
  assign re16 = 16'(re_q);

  assign load = en_i && !tick_i && !busy_q && col_ok_i && row_ok_i;
  assign fin  = (col_cnt_q == (CW+1)'(1)) && (row_cnt_q == (CW+1)'(1));

  // byte select
  always_comb begin
    res_o = '{data: 8'h00, is_data: 1'b1, sel_rel: 1'b0, last: 1'b0};
    unique case (hdr_q)
      HdrColCmd:     res_o = '{data: CmdColumnSet, is_data: 1'b0, sel_rel: 1'b1, last: 1'b0};
      HdrColStartHi: res_o.data = cs16[15:8];
      HdrColStartLo: res_o.data = cs16[7:0];
      HdrColEndHi:   res_o.data = ce16[15:8];
      HdrColEndLo: begin
        res_o.data    = ce16[7:0];
        res_o.sel_rel = 1'b1;
      end
      HdrRowCmd:     res_o = '{data: CmdPageSet, is_data: 1'b0, sel_rel: 1'b1, last: 1'b0};
      HdrRowStartHi: res_o.data = rs16[15:8];
      HdrRowStartLo: res_o.data = rs16[7:0];
      HdrRowEndHi:   res_o.data = re16[15:8];
      HdrRowEndLo: begin
        res_o.data    = re16[7:0];
        res_o.sel_rel = 1'b1;
      end
      HdrRamCmd:     res_o = '{data: CmdMemoryWrite, is_data: 1'b0, sel_rel: 1'b1, last: 1'b0};
      HdrColor: begin
        if (!low_q) begin
          res_o.data = color_q[15:8];
        end else begin
          res_o.data    = color_q[7:0];
          res_o.sel_rel = fin;
          res_o.last    = fin;
        end
      end
      default: res_o = '{data: 8'h00, is_data: 1'b1, sel_rel: 1'b0, last: 1'b0};
    endcase
  end

  // next state
  always_comb begin
    busy_d    = busy_q;
    hdr_d     = hdr_q;
    low_d     = low_q;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (load) begin
      busy_d    = 1'b1;
      hdr_d     = HdrColCmd;
      low_d     = 1'b0;
      col_cnt_d = col_count_i;
      row_cnt_d = row_count_i;
    end else if (en_i && tick_i && busy_q) begin
      if (hdr_q != HdrColor) begin
        hdr_d = hdr_e'(hdr_q + 4'd1);
      end else if (!low_q) begin
        low_d = 1'b1;
      end else begin
        low_d = 1'b0;
        if (fin) begin
          busy_d = 1'b0;
          hdr_d  = HdrColCmd;
        end else if (col_cnt_q == (CW+1)'(1)) begin
          col_cnt_d = width_q;
          row_cnt_d = row_cnt_q - (CW+1)'(1);
        end else begin
          col_cnt_d = col_cnt_q - (CW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hdr_q  <= HdrColCmd;
      low_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      hdr_q  <= hdr_d;
      low_q  <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_cnt_q <= col_cnt_d;
    row_cnt_q <= row_cnt_d;
    if (load) begin
      cs_q    <= col_first_i;
      ce_q    <= col_final_i;
      rs_q    <= row_first_i;
      re_q    <= row_final_i;
      width_q <= col_count_i;
      color_q <= color_i;
    end
  end

  assign status_o = '{busy: busy_q, hdr: hdr_q, low_half: low_q};

endmodule

`default_nettype wire

// ----- hdl/lcd_window_fill_byte_sequencer.sv -----
// Rectangle fill byte sequencer for an LCD controller.
// Input channel (in_valid_i / in_stall_o) carries one beat per item: either a
// fill request (operation_i = 0) with a signed rectangle and RGB565 colour, or a
// tick (operation_i = 1) asking for the next controller byte.
// An accepted request is clipped to the panel (width and height swap for odd
// rotation) and loaded when idle; empty or off-panel requests, and requests
// made while a fill runs, are dropped. Each tick while a fill runs yields one
// result beat on out_valid_o / out_stall_i: column-set command and four bytes,
// page-set command and four bytes, memory-write, then high/low colour bytes.
// A tick beat passes the input register, then the result register, before its
// result appears. One beat per cycle is sustained while out_stall_i is low;
// requests and idle ticks pass straight through the input register.
// When out_stall_i holds the result register, the input register still takes
// one more beat; a further tick then waits and in_stall_o rises.
// Rotation is written through cfg_valid_i / cfg_ready_o; the user must write it only while idle (not enforced).
// Reset clears the sequencer to idle, rotation to 0, both registers to empty.
`default_nettype none

module lcd_window_fill_byte_sequencer
  import lwfb_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 240,
  parameter int unsigned PANEL_HEIGHT = 320
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                operation_i,
  input  wire logic signed [15:0]  rect_x_i,
  input  wire logic signed [15:0]  rect_y_i,
  input  wire logic signed [15:0]  rect_width_i,
  input  wire logic signed [15:0]  rect_height_i,
  input  wire logic        [15:0]  fill_color_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic             [7:0]   spi_byte_o,
  output logic                     is_data_o,
  output logic                     select_release_o,
  output logic                     last_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic        [1:0]   cfg_data_i
);

  localparam int unsigned MaxDim = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int unsigned CW     = $clog2(MaxDim);

  logic [1:0]         rot_q;
  logic               s1_valid_q;
  logic               op_q;
  logic signed [15:0] x_q, y_q, w_q, h_q;
  logic [15:0]        color_q;
  logic               out_valid_q;
  res_t               res_q, res;
  status_t            st;
  logic               in_acc, adv, prod, out_free;
  logic [CW:0]        lim_w, lim_h;
  logic               col_ok, row_ok;
  logic [CW-1:0]      col_first, col_final, row_first, row_final;
  logic [CW:0]        col_count, row_count;

  assign cfg_ready_o = 1'b1;

  assign prod       = (op_q == OpTick) && st.busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && (!prod || out_free);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign lim_w = rot_q[0] ? (CW+1)'(PANEL_HEIGHT) : (CW+1)'(PANEL_WIDTH);
  assign lim_h = rot_q[0] ? (CW+1)'(PANEL_WIDTH)  : (CW+1)'(PANEL_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q       <= 2'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rot_q <= cfg_data_i;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv && prod) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      x_q     <= rect_x_i;
      y_q     <= rect_y_i;
      w_q     <= rect_width_i;
      h_q     <= rect_height_i;
      color_q <= fill_color_i;
    end
    if (adv && prod) begin
      res_q <= res;
    end
  end

  lwfb_clip #(.CW(CW)) u_clip_col (
    .start_i (x_q),
    .size_i  (w_q),
    .limit_i (lim_w),
    .ok_o    (col_ok),
    .first_o (col_first),
    .final_o (col_final),
    .count_o (col_count)
  );

  lwfb_clip #(.CW(CW)) u_clip_row (
    .start_i (y_q),
    .size_i  (h_q),
    .limit_i (lim_h),
    .ok_o    (row_ok),
    .first_o (row_first),
    .final_o (row_final),
    .count_o (row_count)
  );

  lwfb_seq #(.CW(CW)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .tick_i      (op_q == OpTick),
    .col_ok_i    (col_ok),
    .col_first_i (col_first),
    .col_final_i (col_final),
    .col_count_i (col_count),
    .row_ok_i    (row_ok),
    .row_first_i (row_first),
    .row_final_i (row_final),
    .row_count_i (row_count),
    .color_i     (color_q),
    .status_o    (st),
    .res_o       (res)
  );

  assign out_valid_o      = out_valid_q;
  assign spi_byte_o       = res_q.data;
  assign is_data_o        = res_q.is_data;
  assign select_release_o = res_q.sel_rel;
  assign last_o           = res_q.last;

  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st.busy |-> (st.hdr == HdrColCmd) && !st.low_half)
    else $error("idle sequencer not parked at start of header");

  a_low_in_color : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.low_half |-> st.hdr == HdrColor)
    else $error("low colour byte pending outside colour phase");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && prod && res.last) |=> !st.busy)
    else $error("final byte issued but sequencer still busy");

  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && prod && out_valid_q)
    else $error("input stalled without a waiting tick");

endmodule

`default_nettype wire

// ----- tb/sv/lcd_window_fill_byte_sequencer_tb.sv -----
`timescale 1ns / 100ps

module lcd_window_fill_byte_sequencer_tb;
  import lwfb_pkg::*;

  localparam int PanelW     = 240;
  localparam int PanelH     = 320;
  localparam int ClkPeriod  = 8;
  localparam int HoldCycles = 300;
  localparam int PhaseBeats = 170;
  localparam int CycleLimit = 400000;
  localparam logic [5:0][1:0] PhaseRot = {2'd0, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1};

  typedef enum logic [1:0] {
    ChkModel,
    ChkNone,
    ChkByte
  } chk_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] rgb;
    chk_e        chk;
    res_t        golden;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  op_e         operation_i = OpTick;
  logic [15:0] rect_x_i = '0;
  logic [15:0] rect_y_i = '0;
  logic [15:0] rect_width_i = '0;
  logic [15:0] rect_height_i = '0;
  logic [15:0] fill_color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  spi_byte_o;
  logic        is_data_o;
  logic        select_release_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;

  // predictor state
  logic [1:0]  rotation_q = '0;
  logic        fill_busy = 1'b0;
  hdr_e        fill_hdr = HdrColCmd;
  logic [15:0] col_first = '0;
  logic [15:0] col_last = '0;
  logic [15:0] row_first = '0;
  logic [15:0] row_last = '0;
  int          px_remaining = 0;
  logic        low_byte_next = 1'b0;
  logic [15:0] fill_rgb = '0;

  res_t        fill_bytes_q[$];
  res_t        want_byte;
  int          err_cnt = 0;
  int          live_beats = 0;
  int          gap_pct = 25;
  int unsigned cycle_cnt = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  logic        quiet_tail = 1'b0;

  step_row_t dir_rows [24] = '{
    '{OpTick,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ChkNone, '0},
    '{OpRequest, 16'h0000, 16'h0000, 16'h0000, 16'h0005, 16'h1234, ChkNone, '0},
    '{OpRequest, 16'h8000, 16'h0000, 16'h7FFF, 16'h0001, 16'hFFFF, ChkNone, '0},
    '{OpRequest, 16'd240,  16'h0000, 16'h0001, 16'h0001, 16'hFFFF, ChkNone, '0},
    '{OpRequest, 16'h0000, 16'd320,  16'h0001, 16'h0001, 16'hFFFF, ChkNone, '0},
    '{OpRequest, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'hFFFF, ChkNone, '0},
    '{OpTick,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ChkNone, '0},
    '{OpRequest, 16'd239,  16'd319,  16'h7FFF, 16'h7FFF, 16'hF800, ChkNone, '0},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{CmdColumnSet, 1'b0, 1'b1, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'hEF, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'hEF, 1'b1, 1'b1, 1'b0}},
    '{OpRequest, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000, ChkNone, '0},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{CmdPageSet, 1'b0, 1'b1, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h01, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h3F, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h01, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h3F, 1'b1, 1'b1, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{CmdMemoryWrite, 1'b0, 1'b1, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'hF8, 1'b1, 1'b0, 1'b0}},
    '{OpTick, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, ChkByte, '{8'h00, 1'b1, 1'b1, 1'b1}},
    '{OpTick,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ChkNone, '0},
    // negative start, left unfinished so rotation changes mid-fill
    '{OpRequest, 16'hFFFF, 16'hFFFE, 16'h0003, 16'h0003, 16'h07E0, ChkNone, '0}
  };

  lcd_window_fill_byte_sequencer #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .fill_color_i    (fill_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .spi_byte_o      (spi_byte_o),
    .is_data_o       (is_data_o),
    .select_release_o(select_release_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // next controller byte, or a new window load
  function automatic bit advance_fill(input op_e op, input logic signed [15:0] x16,
                                      input logic signed [15:0] y16,
                                      input logic signed [15:0] w16,
                                      input logic signed [15:0] h16,
                                      input logic [15:0] rgb, output res_t r);
    int lw;
    int lh;
    int x;
    int y;
    int w;
    int h;
    r = '0;
    if (op == OpRequest) begin
      lw = rotation_q[0] ? PanelH : PanelW;
      lh = rotation_q[0] ? PanelW : PanelH;
      x = int'(x16);
      y = int'(y16);
      w = int'(w16);
      h = int'(h16);
      if (fill_busy || w <= 0 || h <= 0 || x >= lw || y >= lh) return 1'b0;
      if (x < 0) begin
        w += x;
        x = 0;
      end
      if (y < 0) begin
        h += y;
        y = 0;
      end
      if (w <= 0 || h <= 0) return 1'b0;
      if (x + w > lw) w = lw - x;
      if (y + h > lh) h = lh - y;
      col_first = 16'(x);
      col_last = 16'(x + w - 1);
      row_first = 16'(y);
      row_last = 16'(y + h - 1);
      px_remaining = w * h;
      fill_rgb = rgb;
      low_byte_next = 1'b0;
      fill_hdr = HdrColCmd;
      fill_busy = 1'b1;
      return 1'b0;
    end
    if (!fill_busy) return 1'b0;
    if (fill_hdr != HdrColor) begin
      case (fill_hdr)
        HdrColCmd:     r = '{CmdColumnSet, 1'b0, 1'b1, 1'b0};
        HdrColStartHi: r = '{col_first[15:8], 1'b1, 1'b0, 1'b0};
        HdrColStartLo: r = '{col_first[7:0], 1'b1, 1'b0, 1'b0};
        HdrColEndHi:   r = '{col_last[15:8], 1'b1, 1'b0, 1'b0};
        HdrColEndLo:   r = '{col_last[7:0], 1'b1, 1'b1, 1'b0};
        HdrRowCmd:     r = '{CmdPageSet, 1'b0, 1'b1, 1'b0};
        HdrRowStartHi: r = '{row_first[15:8], 1'b1, 1'b0, 1'b0};
        HdrRowStartLo: r = '{row_first[7:0], 1'b1, 1'b0, 1'b0};
        HdrRowEndHi:   r = '{row_last[15:8], 1'b1, 1'b0, 1'b0};
        HdrRowEndLo:   r = '{row_last[7:0], 1'b1, 1'b1, 1'b0};
        default:       r = '{CmdMemoryWrite, 1'b0, 1'b1, 1'b0};
      endcase
      fill_hdr = hdr_e'(fill_hdr + 4'd1);
      return 1'b1;
    end
    if (!low_byte_next) begin
      r = '{fill_rgb[15:8], 1'b1, 1'b0, 1'b0};
      low_byte_next = 1'b1;
      return 1'b1;
    end
    low_byte_next = 1'b0;
    if (px_remaining > 0) px_remaining--;
    if (px_remaining == 0) begin
      r = '{fill_rgb[7:0], 1'b1, 1'b1, 1'b1};
      fill_busy = 1'b0;
      fill_hdr = HdrColCmd;
    end else begin
      r = '{fill_rgb[7:0], 1'b1, 1'b0, 1'b0};
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input op_e op, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] rgb, input chk_e chk, input res_t golden);
    bit   made;
    bit   was_busy;
    res_t got;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    rect_x_i      <= x;
    rect_y_i      <= y;
    rect_width_i  <= w;
    rect_height_i <= h;
    fill_color_i  <= rgb;
    do @(posedge clk_i); while (in_stall_o);
    was_busy = fill_busy;
    made = advance_fill(op, x, y, w, h, rgb, got);
    if (made || (!was_busy && fill_busy)) live_beats++;
    case (chk)
      ChkModel: if (made) fill_bytes_q.push_back(got);
      ChkByte:  fill_bytes_q.push_back(golden);
      default:  ;
    endcase
  endtask

  task automatic send_tick;
    send_beat(OpTick, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), ChkModel, '0);
  endtask

  task automatic write_rotation(input logic [1:0] rot);
    in_valid_i <= 1'b0;
    while (fill_bytes_q.size() != 0) @(posedge clk_i);
    // let requests and idle ticks drain from the pipe
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= rot;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    rotation_q = rot;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_sequence;
    int          lw;
    int          lh;
    int          pick;
    int          x;
    int          y;
    int          w;
    int          h;
    int          k;
    int          cut;
    int          n;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nw;
    logic [15:0] nh;
    lw = rotation_q[0] ? PanelH : PanelW;
    lh = rotation_q[0] ? PanelW : PanelH;
    pick = $urandom_range(99);
    if (pick < 10) begin
      nx = 16'($urandom);
      ny = 16'($urandom);
      nw = 16'($urandom);
      nh = 16'($urandom);
      if (!nw[15] && !nh[15]) nh = {15'd0, nh[0]};
      send_beat(OpRequest, nx, ny, nw, nh, 16'($urandom), ChkModel, '0);
      return;
    end
    if (pick < 15) begin
      send_tick();
      return;
    end
    x = $urandom_range(0, lw - 1);
    y = $urandom_range(0, lh - 1);
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    case ($urandom_range(4))
      1: begin
        x = lw - $urandom_range(1, 4);
        w = $urandom_range(1, 32767);
        h = $urandom_range(1, 2);
      end
      2: begin
        y = lh - $urandom_range(1, 4);
        h = $urandom_range(1, 32767);
        w = $urandom_range(1, 2);
      end
      3: begin
        k = ($urandom_range(1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 32767);
        x = -k;
        w = (k + $urandom_range(0, 3) > 32767) ? 32767 : k + $urandom_range(0, 3);
        if ($urandom_range(1) != 0) begin
          k = $urandom_range(1, 8);
          y = -k;
          h = k + $urandom_range(0, 2);
        end
      end
      default: ;
    endcase
    send_beat(OpRequest, x[15:0], y[15:0], w[15:0], h[15:0], 16'($urandom), ChkModel, '0);
    cut = ($urandom_range(99) < 8) ? $urandom_range(1, 20) : 800;
    n = 0;
    while (fill_busy && n < cut) begin
      if ($urandom_range(99) < 3)
        send_beat(OpRequest, 16'd0, 16'd0, 16'd1, 16'd1, 16'($urandom), ChkModel, '0);
      send_tick();
      n++;
    end
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fill_bytes_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, got %0h", $time, spi_byte_o);
      end else begin
        want_byte = fill_bytes_q.pop_front();
        check_field("spi_byte", int'(want_byte.data), int'(spi_byte_o));
        check_field("is_data", int'(want_byte.is_data), int'(is_data_o));
        check_field("select_release", int'(want_byte.sel_rel), int'(select_release_o));
        check_field("last", int'(want_byte.last), int'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, quiet at the end
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (quiet_tail) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if ($urandom_range(99) < 30) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w, dir_rows[i].h,
                dir_rows[i].rgb, dir_rows[i].chk, dir_rows[i].golden);
    for (int ph = 0; ph < 6; ph++) begin
      write_rotation(PhaseRot[ph]);
      gap_pct = 25;
      if (ph == 1) begin
        hold_go <= 1'b1;
        gap_pct = 0;
      end
      if (ph == 5) begin
        quiet_tail <= 1'b1;
        gap_pct = 0;
      end
      while (live_beats < (ph + 1) * PhaseBeats) run_sequence();
    end
    in_valid_i <= 1'b0;
    while (fill_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
